// File: design/flv_pkg.sv
package flv_pkg;

  // Stream layout constants.
  localparam int unsigned FILE_HDR_BYTES  = 9;
  localparam int unsigned PREV_SIZE_BYTES = 4;
  localparam int unsigned TAG_HDR_BYTES   = 11;
  localparam int unsigned FILE_SKIP_BYTES = FILE_HDR_BYTES + PREV_SIZE_BYTES;

  localparam logic [31:0] EXT_STAMP_MASK = 32'hff00_0000;

  // Tag type codes.
  localparam logic [7:0] TYPE_AUDIO = 8'd8;
  localparam logic [7:0] TYPE_VIDEO = 8'd9;

  // Result item kinds.
  localparam logic ITEM_HEADER  = 1'b0;
  localparam logic ITEM_PAYLOAD = 1'b1;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_FILE_SKIP = 3'd0,
    PH_HEADER    = 3'd1,
    PH_PAYLOAD   = 3'd2,
    PH_TRAILER   = 3'd3
  } phase_t;

  // One result item.
  typedef struct packed {
    logic        item_kind;
    logic        is_video;
    logic [23:0] payload_size;
    logic [31:0] time_stamp;
    logic [23:0] stream_ident;
    logic [7:0]  payload_byte;
    logic        last_of_tag;
  } result_t;

endpackage

// File: design/flv_byte_if.sv
interface flv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

// File: design/flv_item_if.sv
interface flv_item_if;
  import flv_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/flv_tag_stream_deframer_unit.sv
// FLV tag deframer: takes one stream byte per clock and parses it in the same cycle against
// the parser state, so the block sustains one byte per cycle while the sink keeps up; each
// result appears in the next cycle. The file header and first previous-tag-size (13 bytes),
// every trailing previous-tag-size and the payload of tags other than audio and video are
// consumed without results. Each audio or video tag yields a header request carrying the
// tag metadata, then one request per payload byte; the final one is marked last_of_tag.
// Results sit in a single output register; the byte channel's ready follows that register
// (free, or being drained this cycle), so a stalled sink stalls the input directly.
module flv_tag_stream_deframer_unit (
  input  logic clk,
  input  logic rst,
  flv_byte_if.sink   bytes,
  flv_item_if.source items
);
  import flv_pkg::*;

  // Parser state.
  phase_t      phase,      phase_next;
  logic [23:0] byte_count, byte_count_next;
  logic [7:0]  tag_kind,   tag_kind_next;
  logic [23:0] size_reg,   size_reg_next;
  logic [31:0] stamp_reg,  stamp_reg_next;
  logic [23:0] ident_reg,  ident_reg_next;
  logic        keep_tag,   keep_tag_next;

  // Output register.
  logic    out_valid;
  result_t out_data;

  logic        accept;
  logic        emit;
  result_t     res;
  logic [23:0] count_inc;
  logic [23:0] hdr_count;
  logic [23:0] hdr_inc;
  logic [7:0]  b;

  assign bytes.ready = !out_valid || items.ready;
  assign accept      = bytes.valid && bytes.ready;
  assign items.valid = out_valid;
  assign items.data  = out_data;
  assign b           = bytes.stream_byte;

  assign count_inc = byte_count + 24'd1;
  assign hdr_count = (phase == PH_HEADER) ? byte_count : 24'd0;
  assign hdr_inc   = hdr_count + 24'd1;

  // Next state and result for the byte on the input.
  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    tag_kind_next   = tag_kind;
    size_reg_next   = size_reg;
    stamp_reg_next  = stamp_reg;
    ident_reg_next  = ident_reg;
    keep_tag_next   = keep_tag;
    emit            = 1'b0;
    res             = '0;

    case (phase)
      PH_FILE_SKIP: begin
        byte_count_next = count_inc;
        if (count_inc >= 24'(FILE_SKIP_BYTES)) begin
          phase_next      = PH_HEADER;
          byte_count_next = '0;
        end
      end

      PH_PAYLOAD: begin
        emit             = keep_tag;
        res.item_kind    = ITEM_PAYLOAD;
        res.is_video     = (tag_kind == TYPE_VIDEO);
        res.payload_size = size_reg;
        res.time_stamp   = stamp_reg;
        res.stream_ident = ident_reg;
        res.payload_byte = b;
        res.last_of_tag  = (count_inc == size_reg);
        byte_count_next  = count_inc;
        if (count_inc == size_reg) begin
          phase_next      = PH_TRAILER;
          byte_count_next = '0;
        end
      end

      PH_TRAILER: begin
        byte_count_next = count_inc;
        if (count_inc >= 24'(PREV_SIZE_BYTES)) begin
          phase_next      = PH_HEADER;
          byte_count_next = '0;
        end
      end

      // Tag header; unused phase codes restart a header here.
      default: begin
        phase_next = PH_HEADER;
        case (hdr_count)
          24'd0: begin
            tag_kind_next  = b;
            size_reg_next  = '0;
            stamp_reg_next = '0;
            ident_reg_next = '0;
          end
          24'd1, 24'd2, 24'd3: size_reg_next = {size_reg[15:0], b};
          24'd4, 24'd5, 24'd6: stamp_reg_next = {8'd0, stamp_reg[15:0], b};
          24'd7: stamp_reg_next = (stamp_reg & ~EXT_STAMP_MASK) | ({b, 24'd0} & EXT_STAMP_MASK);
          default: ident_reg_next = {ident_reg[15:0], b};
        endcase
        byte_count_next = hdr_inc;
        if (hdr_inc >= 24'(TAG_HDR_BYTES)) begin
          keep_tag_next    = (tag_kind_next == TYPE_AUDIO) || (tag_kind_next == TYPE_VIDEO);
          emit             = keep_tag_next;
          res.item_kind    = ITEM_HEADER;
          res.is_video     = (tag_kind_next == TYPE_VIDEO);
          res.payload_size = size_reg_next;
          res.time_stamp   = stamp_reg_next;
          res.stream_ident = ident_reg_next;
          res.payload_byte = '0;
          res.last_of_tag  = (size_reg_next == 24'd0);
          byte_count_next  = '0;
          phase_next       = (size_reg_next == 24'd0) ? PH_TRAILER : PH_PAYLOAD;
        end
      end
    endcase
  end

  // State registers, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FILE_SKIP;
      byte_count <= '0;
      tag_kind   <= '0;
      size_reg   <= '0;
      stamp_reg  <= '0;
      ident_reg  <= '0;
      keep_tag   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      tag_kind   <= tag_kind_next;
      size_reg   <= size_reg_next;
      stamp_reg  <= stamp_reg_next;
      ident_reg  <= ident_reg_next;
      keep_tag   <= keep_tag_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (items.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data <= res;
    end
  end

  // A kept payload byte always produces a request in the next cycle.
  a_payload_emits: assert property (@(posedge clk) disable iff (rst)
    accept && (phase == PH_PAYLOAD) && keep_tag |=> out_valid)
    else $error("kept payload byte produced no request");

  // Header requests carry a zero payload byte and mark last exactly for empty tags.
  a_header_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.item_kind == ITEM_HEADER) |->
      (out_data.payload_byte == 8'd0) && (out_data.last_of_tag == (out_data.payload_size == 24'd0)))
    else $error("malformed header request");

  // Nothing is produced while the file header is being skipped.
  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (phase == PH_FILE_SKIP) |=> !out_valid)
    else $error("request produced during file header skip");

endmodule

// File: tb/flv_tag_stream_deframer_unit_test.sv
module flv_tag_stream_deframer_unit_test;
  import flv_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 2000;
  localparam int unsigned CALM_FROM    = 1700;

  // Tracks the parser state, holds the items still due and checks arrivals.
  class deframe_checker;
    phase_t      ph;
    logic [23:0] cnt;
    logic [7:0]  kind;
    logic [23:0] size;
    logic [31:0] stamp;
    logic [23:0] ident;
    bit          keep;
    result_t     due_items[$];
    int          errors;

    function new();
      ph     = PH_FILE_SKIP;
      cnt    = '0;
      kind   = '0;
      size   = '0;
      stamp  = '0;
      ident  = '0;
      keep   = 1'b0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Builds an item from the metadata of the current tag.
    function result_t make_item(input logic kind_bit, input logic [7:0] pbyte,
                                input logic last);
      result_t r;
      r.item_kind    = kind_bit;
      r.is_video     = (kind == TYPE_VIDEO);
      r.payload_size = size;
      r.time_stamp   = stamp;
      r.stream_ident = ident;
      r.payload_byte = pbyte;
      r.last_of_tag  = last;
      return r;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte yields an item.
    function bit parse_byte(input logic [7:0] b, output result_t r);
      bit hit;
      hit = 1'b0;
      r   = '0;
      case (ph)
        PH_FILE_SKIP: begin
          cnt = cnt + 24'd1;
          if (cnt >= FILE_SKIP_BYTES) begin
            ph  = PH_HEADER;
            cnt = '0;
          end
        end
        PH_PAYLOAD: begin
          if (keep) begin
            r   = make_item(ITEM_PAYLOAD, b, (cnt + 24'd1) == size);
            hit = 1'b1;
          end
          cnt = cnt + 24'd1;
          if (cnt == size) begin
            ph  = PH_TRAILER;
            cnt = '0;
          end
        end
        PH_TRAILER: begin
          cnt = cnt + 24'd1;
          if (cnt >= PREV_SIZE_BYTES) begin
            ph  = PH_HEADER;
            cnt = '0;
          end
        end
        default: begin
          if (ph != PH_HEADER) begin
            ph  = PH_HEADER;
            cnt = '0;
          end
          // Header bytes are big-endian; the eighth byte is the extended stamp.
          if (cnt == 0) begin
            kind  = b;
            size  = '0;
            stamp = '0;
            ident = '0;
          end else if (cnt <= 3) begin
            size = {size[15:0], b};
          end else if (cnt <= 6) begin
            stamp = {8'h00, stamp[15:0], b};
          end else if (cnt == 7) begin
            stamp = {b, stamp[23:0]};
          end else begin
            ident = {ident[15:0], b};
          end
          cnt = cnt + 24'd1;
          if (cnt >= TAG_HDR_BYTES) begin
            keep = (kind == TYPE_AUDIO) || (kind == TYPE_VIDEO);
            if (keep) begin
              r   = make_item(ITEM_HEADER, 8'h00, size == 0);
              hit = 1'b1;
            end
            cnt = '0;
            ph  = (size == 0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
      endcase
      return hit;
    endfunction

    function void note_byte(input logic [7:0] b);
      result_t r;
      if (parse_byte(b, r)) due_items.push_back(r);
    endfunction

    task check_item(input result_t got);
      result_t want;
      if (due_items.size() == 0) begin
        report($sformatf("item with nothing due: %h", got));
      end else begin
        want = due_items.pop_front();
        if (got.item_kind !== want.item_kind)
          report($sformatf("item_kind %0h, want %0h", got.item_kind, want.item_kind));
        if (got.is_video !== want.is_video)
          report($sformatf("is_video %0h, want %0h", got.is_video, want.is_video));
        if (got.payload_size !== want.payload_size)
          report($sformatf("payload_size %0h, want %0h", got.payload_size,
                           want.payload_size));
        if (got.time_stamp !== want.time_stamp)
          report($sformatf("time_stamp %0h, want %0h", got.time_stamp, want.time_stamp));
        if (got.stream_ident !== want.stream_ident)
          report($sformatf("stream_ident %0h, want %0h", got.stream_ident,
                           want.stream_ident));
        if (got.payload_byte !== want.payload_byte)
          report($sformatf("payload_byte %0h, want %0h", got.payload_byte,
                           want.payload_byte));
        if (got.last_of_tag !== want.last_of_tag)
          report($sformatf("last_of_tag %0h, want %0h", got.last_of_tag,
                           want.last_of_tag));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int unsigned cycles;
  int unsigned bytes_sent;
  int   ready_hold;
  deframe_checker chk;

  flv_byte_if byte_ch();
  flv_item_if item_ch();

  flv_tag_stream_deframer_unit dut (
    .clk  (clk),
    .rst  (rst),
    .bytes(byte_ch),
    .items(item_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check accepted items and stall ready in random bursts.
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) chk.check_item(item_ch.data);
    if (rst) begin
      item_ch.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      item_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 10);
      item_ch.ready <= 1'b0;
    end else begin
      item_ch.ready <= 1'b1;
    end
  end

  // Offers one byte, with an occasional idle burst first, and waits for acceptance.
  task send_byte(input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.stream_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    chk.note_byte(b);
    bytes_sent++;
  endtask

  task send_tag_header(input logic [7:0] kind, input logic [23:0] size,
                       input logic [31:0] stamp, input logic [23:0] ident);
    send_byte(kind);
    send_byte(size[23:16]);
    send_byte(size[15:8]);
    send_byte(size[7:0]);
    send_byte(stamp[23:16]);
    send_byte(stamp[15:8]);
    send_byte(stamp[7:0]);
    send_byte(stamp[31:24]);
    send_byte(ident[23:16]);
    send_byte(ident[15:8]);
    send_byte(ident[7:0]);
  endtask

  // Whole tag: header, random payload, random previous-tag-size.
  task send_tag(input logic [7:0] kind, input logic [23:0] size,
                input logic [31:0] stamp, input logic [23:0] ident);
    send_tag_header(kind, size, stamp, ident);
    for (int i = 0; i < size; i++) send_byte(8'($urandom));
    repeat (PREV_SIZE_BYTES) send_byte(8'($urandom));
  endtask

  task send_file_header();
    send_byte("F");
    send_byte("L");
    send_byte("V");
    send_byte(8'h01);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h09);
    repeat (PREV_SIZE_BYTES) send_byte(8'h00);
  endtask

  task send_random_tag();
    logic [7:0]  kind;
    logic [23:0] size;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)      kind = TYPE_AUDIO;
    else if (pick < 8) kind = TYPE_VIDEO;
    else               kind = 8'($urandom);
    if ($urandom_range(0, 19) == 0) size = 24'($urandom_range(25, 300));
    else                            size = 24'($urandom_range(0, 24));
    send_tag(kind, size, $urandom, 24'($urandom));
  endtask

  initial begin
    chk        = new();
    calm       = 1'b0;
    bytes_sent = 0;
    rst        = 1'b1;
    byte_ch.valid       <= 1'b0;
    byte_ch.stream_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty payload, extreme metadata, other tag types.
    send_file_header();
    send_tag(TYPE_AUDIO, 24'd0, 32'h0000_0000, 24'h00_0000);
    send_tag(TYPE_VIDEO, 24'd1, 32'hffff_ffff, 24'hff_ffff);
    send_tag(8'd18, 24'd3, 32'h0102_0304, 24'h00_0001);
    send_tag(8'hff, 24'd0, 32'h8000_0000, 24'h80_0000);
    send_tag(TYPE_AUDIO, 24'd2, 32'h1234_5678, 24'h5a_a55a);

    // Random tags; the last stretch runs without idling on either side.
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= CALM_FROM) calm = 1'b1;
      send_random_tag();
    end
    calm = 1'b1;

    // A tag of the largest size, fed only for a few payload bytes.
    send_tag_header(TYPE_VIDEO, 24'hff_ffff, $urandom, 24'($urandom));
    repeat (8) send_byte(8'($urandom));
    byte_ch.valid <= 1'b0;

    while (chk.due_items.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (chk.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
